// File: hw/rtl/set_assoc_cache_tag_controller_assert.svh
// Assertion macros shared by the checker of the cache tag controller.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define SACTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that an antecedent implies a consequent in the cycle after it.
`define SACTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/sactc_pkg.sv
// Package with the sizes, mode codes and command types of the cache tag controller.
`timescale 1ns / 1ps
package sactc_pkg;
	localparam int unsigned WaysDefault = 4;
	localparam int unsigned SetsDefault = 64;
	localparam int unsigned LineAddressBitsDefault = 26;
	localparam int unsigned AgeBitsDefault = 8;
	localparam int unsigned ModeBits = 2;
	localparam int unsigned WayFieldBits = 2;
	localparam int unsigned TdataInBits = 32;
	localparam int unsigned TdataOutBits = 32;

	typedef enum logic [ModeBits-1:0] {
		MODE_RR  = 2'd0,
		MODE_NRU = 2'd1,
		MODE_LRU = 2'd2,
		MODE_ALT = 2'd3
	} mode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic lookup;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
		logic busy;
	} dp_status_t;
endpackage

// File: hw/rtl/sactc_ctrl.sv
// Controller state machine that sequences read, compare and update of one request.
`timescale 1ns / 1ps
module sactc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sactc_pkg::dp_cmd_t   cmd,
	input  sactc_pkg::dp_status_t status
);
	import sactc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// A new request enters while the controller is idle, the set state is cleared and the result register
	// is empty or being drained.
	assign in_ready = (state_q == ST_IDLE) && !status.busy && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd.lookup = in_valid && in_ready;
	assign cmd.commit = (state_q == ST_UPDATE);

	// State and result-valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (status.done) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// File: hw/rtl/sactc_datapath.sv
// Datapath with set memories, tag compare, victim choice and state update.
`timescale 1ns / 1ps
module sactc_datapath #(
	parameter int unsigned WAYS = sactc_pkg::WaysDefault,
	parameter int unsigned SETS = sactc_pkg::SetsDefault,
	parameter int unsigned LINE_ADDRESS_BITS = sactc_pkg::LineAddressBitsDefault,
	parameter int unsigned AGE_BITS = sactc_pkg::AgeBitsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sactc_pkg::dp_cmd_t             cmd,
	output sactc_pkg::dp_status_t          status,
	input  logic [sactc_pkg::ModeBits-1:0] mode,
	input  logic                           req_type,
	input  logic [LINE_ADDRESS_BITS-1:0]   line_address,
	output logic                           hit,
	output logic [sactc_pkg::WayFieldBits-1:0] way,
	output logic                           filled_empty,
	output logic                           evicted_valid,
	output logic                           writeback_needed,
	output logic [LINE_ADDRESS_BITS-1:0]   victim_line
);
	import sactc_pkg::*;

	localparam int unsigned SetBits = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int unsigned SetUsed = $clog2(SETS);
	localparam int unsigned TagBits = LINE_ADDRESS_BITS - SetUsed;
	localparam int unsigned WayBits = $clog2(WAYS);
	localparam logic [AGE_BITS-1:0] AgeMax = {AGE_BITS{1'b1}};

	typedef logic [WAYS-1:0][TagBits-1:0]  tag_row_t;
	typedef logic [WAYS-1:0][AGE_BITS-1:0] age_row_t;

	// Per-set rows; tags are undefined until written.
	tag_row_t          tag_mem [SETS];
	logic [WAYS-1:0]   valid_q [SETS];
	logic [WAYS-1:0]   dirty_q [SETS];
	logic [WAYS-1:0]   mark_q  [SETS];
	age_row_t          age_q   [SETS];
	logic [WayBits-1:0] rr_q   [SETS];

	// Request registers and registered reads of the set.
	logic [SetBits-1:0] set_q;
	logic [TagBits-1:0] tag_q;
	logic               wr_q;
	mode_t              mode_q;
	tag_row_t           tags_s1;
	logic [WAYS-1:0]    valid_s1, dirty_s1, mark_s1;
	age_row_t           ages_s1;
	logic [WayBits-1:0] rr_s1;

	// Clearing pass state after reset.
	logic               clr_busy_q;
	logic [SetBits-1:0] clr_set_q;

	logic [SetBits-1:0] set_idx;
	generate
		if (SETS > 1) begin : g_set
			assign set_idx = line_address[SetBits-1:0];
		end else begin : g_one
			assign set_idx = '0;
		end
	endgenerate

	// Read the set row and capture the request.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			set_q <= set_idx;
			tag_q <= line_address[LINE_ADDRESS_BITS-1:SetUsed];
			wr_q <= req_type;
			mode_q <= (mode == MODE_ALT) ? MODE_LRU : mode_t'(mode);
			tags_s1 <= tag_mem[set_idx];
			valid_s1 <= valid_q[set_idx];
			dirty_s1 <= dirty_q[set_idx];
			mark_s1 <= mark_q[set_idx];
			ages_s1 <= age_q[set_idx];
			rr_s1 <= rr_q[set_idx];
		end
	end

	// Compare, victim search and next row contents.
	logic               hit_c, inv_found, unmk_found, ev_c;
	logic [WayBits-1:0] hit_way, inv_way, unmk_way, old_way, w_c;
	logic [WAYS-1:0]    valid_n, dirty_n, mark_n;
	age_row_t           ages_n;
	logic [WayBits-1:0] rr_n;
	logic [AGE_BITS-1:0] best_age;

	always_comb begin
		hit_c = 1'b0;
		hit_way = '0;
		inv_found = 1'b0;
		inv_way = '0;
		unmk_found = 1'b0;
		unmk_way = '0;
		old_way = '0;
		best_age = ages_s1[0];
		for (int j = 0; j < WAYS; j++) begin
			if (!hit_c && valid_s1[j] && tags_s1[j] == tag_q) begin
				hit_c = 1'b1;
				hit_way = WayBits'(j);
			end
			if (!inv_found && !valid_s1[j]) begin
				inv_found = 1'b1;
				inv_way = WayBits'(j);
			end
			if (!mark_s1[j]) begin
				unmk_found = 1'b1;
				unmk_way = WayBits'(j);
			end
			if (ages_s1[j] > best_age) begin
				best_age = ages_s1[j];
				old_way = WayBits'(j);
			end
		end
		mark_n = mark_s1;
		rr_n = rr_s1;
		if (hit_c) begin
			w_c = hit_way;
		end else if (mode_q == MODE_RR) begin
			w_c = rr_s1;
			rr_n = (rr_s1 == WayBits'(WAYS - 1)) ? '0 : rr_s1 + 1'b1;
		end else if (inv_found) begin
			w_c = inv_way;
		end else if (mode_q == MODE_NRU) begin
			w_c = unmk_found ? unmk_way : '0;
			if (!unmk_found) begin
				mark_n = '0;
			end
		end else begin
			w_c = old_way;
		end
		ev_c = !hit_c && valid_s1[w_c];
		valid_n = valid_s1;
		dirty_n = dirty_s1;
		if (!hit_c) begin
			valid_n[w_c] = 1'b1;
			dirty_n[w_c] = 1'b0;
			mark_n[w_c] = (mode_q == MODE_NRU);
		end else if (mode_q == MODE_NRU) begin
			mark_n[w_c] = 1'b1;
		end
		if (wr_q) begin
			dirty_n[w_c] = 1'b1;
		end
		ages_n = ages_s1;
		if (mode_q == MODE_LRU) begin
			for (int j = 0; j < WAYS; j++) begin
				if (WayBits'(j) == w_c) begin
					ages_n[j] = '0;
				end else if (ages_s1[j] != AgeMax) begin
					ages_n[j] = ages_s1[j] + 1'b1;
				end
			end
		end
	end

	// Write the tag of a fill.
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_c) begin
			tag_mem[set_q][w_c] <= tag_q;
		end
	end

	// After reset, walk every set once, one row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_set_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_set_q == SetBits'(SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_set_q <= clr_set_q + 1'b1;
			end
		end
	end

	// Control state of every set, cleared by the pass after reset.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			valid_q[clr_set_q] <= '0;
			dirty_q[clr_set_q] <= '0;
			mark_q[clr_set_q] <= '0;
			age_q[clr_set_q] <= '0;
			rr_q[clr_set_q] <= '0;
		end else if (cmd.commit) begin
			valid_q[set_q] <= valid_n;
			dirty_q[set_q] <= dirty_n;
			mark_q[set_q] <= mark_n;
			age_q[set_q] <= ages_n;
			rr_q[set_q] <= rr_n;
		end
	end

	// Result register.
	logic [LINE_ADDRESS_BITS-1:0] victim_c;
	generate
		if (SETS > 1) begin : g_vic
			assign victim_c = {tags_s1[w_c], set_q};
		end else begin : g_vic1
			assign victim_c = tags_s1[w_c];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit <= hit_c;
			way <= WayFieldBits'({{WayFieldBits{1'b0}}, w_c});
			filled_empty <= !hit_c && !ev_c;
			evicted_valid <= ev_c;
			writeback_needed <= ev_c && dirty_s1[w_c];
			victim_line <= ev_c ? victim_c : '0;
		end
	end

	assign status.done = cmd.commit;
	assign status.busy = clr_busy_q;
endmodule

// File: hw/rtl/set_assoc_cache_tag_controller.sv
// A result is offered once its request has passed the READ and UPDATE states: set read at the accept edge.
// No new request is taken until the last one is back in IDLE; the set row read-modify-write bounds the rate.
// The result waits in an output register; no request is taken until it is accepted.
// Reset sets the replacement mode to age-counter LRU and starts a clearing pass over all SETS
// sets (64 by default) of valid, dirty, marker, age and pointer state.
// Requests wait until the clearing pass is over.
`timescale 1ns / 1ps
module set_assoc_cache_tag_controller #(
	parameter int unsigned WAYS = sactc_pkg::WaysDefault,
	parameter int unsigned SETS = sactc_pkg::SetsDefault,
	parameter int unsigned LINE_ADDRESS_BITS = sactc_pkg::LineAddressBitsDefault,
	parameter int unsigned AGE_BITS = sactc_pkg::AgeBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [sactc_pkg::ModeBits-1:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: req_type [0], line_address [LINE_ADDRESS_BITS:1], zero fill
	input  logic [((LINE_ADDRESS_BITS+8)/8)*8-1:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: hit, way[2], filled_empty, evicted_valid, writeback_needed, victim_line
	output logic [((LINE_ADDRESS_BITS+13)/8)*8-1:0] m_axis_tdata
);
	import sactc_pkg::*;

	localparam int unsigned OutBits = ((LINE_ADDRESS_BITS + 13) / 8) * 8;

	logic [ModeBits-1:0] mode_q;
	dp_cmd_t cmd;
	dp_status_t status;
	logic hit, fe, ev, wb;
	logic [WayFieldBits-1:0] way;
	logic [LINE_ADDRESS_BITS-1:0] victim;

	// Replacement mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeBits'(MODE_LRU);
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	sactc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .status(status)
	);

	sactc_datapath #(
		.WAYS(WAYS), .SETS(SETS), .LINE_ADDRESS_BITS(LINE_ADDRESS_BITS), .AGE_BITS(AGE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .mode(mode_q),
		.req_type(s_axis_tdata[0]),
		.line_address(s_axis_tdata[LINE_ADDRESS_BITS:1]),
		.hit(hit), .way(way), .filled_empty(fe), .evicted_valid(ev),
		.writeback_needed(wb), .victim_line(victim)
	);

	assign m_axis_tdata = OutBits'({victim, wb, ev, fe, way, hit});
endmodule

// File: hw/rtl/sactc_checker.sv
// Port-level checker of the cache tag controller, bound to the top level.
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_controller_assert.svh"
module sactc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	// A transaction in is never followed at once by an offered result.
	`SACTC_ASSERT_NEXT(a_no_early, clk, arst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
	// No new request is taken in the cycle after one was taken.
	`SACTC_ASSERT_NEXT(a_gap, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A hit never reports a fill of an empty way, an eviction or a write-back.
	`SACTC_ASSERT_IMP(a_hit_clean, clk, arst_n, m_axis_tvalid && m_axis_tdata[0],
		!m_axis_tdata[3] && !m_axis_tdata[4] && !m_axis_tdata[5])
	// Write-back only follows an eviction of a valid line.
	`SACTC_ASSERT_IMP(a_wb_ev, clk, arst_n, m_axis_tvalid && m_axis_tdata[5], m_axis_tdata[4])
endmodule

bind set_assoc_cache_tag_controller sactc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// File: verif/tb_top.sv
// Self-checking testbench for the set-associative cache tag controller.
`timescale 1ns / 1ps
module tb_top;
	import sactc_pkg::*;

	localparam int NumWays = 4;
	localparam int NumSets = 64;

	typedef struct packed {
		logic [25:0] victim_line;
		logic        writeback_needed;
		logic        evicted_valid;
		logic        filled_empty;
		logic [1:0]  way;
		logic        hit;
	} lookup_t;

	typedef struct {
		bit          is_write;
		logic [25:0] line_address;
		bit          typed;
		lookup_t     known;
	} req_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	// Shadow copy of the cache directory.
	logic [19:0] tag_store [NumSets][NumWays];
	bit          line_valid [NumSets][NumWays];
	bit          line_dirty [NumSets][NumWays];
	bit          nru_mark [NumSets][NumWays];
	bit [7:0]    lru_age [NumSets][NumWays];
	bit [1:0]    rr_next [NumSets];
	mode_t       repl_mode;

	lookup_t     pending_lookups[$];
	int          fail_count;
	bit          quiet;
	bit          hold_req;
	int          stall_left;

	set_assoc_cache_tag_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Age every way of the set but the touched one, saturating.
	function automatic void touch_age(int s, int w);
		for (int j = 0; j < NumWays; j++) begin
			if (j == w)
				lru_age[s][j] = 8'd0;
			else if (lru_age[s][j] != 8'hFF)
				lru_age[s][j]++;
		end
	endfunction

	// Look up one request in the shadow directory and update it.
	function automatic lookup_t lookup_line(bit is_write, logic [25:0] addr);
		lookup_t r;
		int s;
		logic [19:0] t;
		int w;
		bit found;
		mode_t m;
		r = '0;
		s = addr[5:0];
		t = addr[25:6];
		w = 0;
		m = (repl_mode == MODE_ALT) ? MODE_LRU : repl_mode;
		for (int j = 0; j < NumWays; j++) begin
			if (!r.hit && line_valid[s][j] && tag_store[s][j] == t) begin
				r.hit = 1'b1;
				w = j;
			end
		end
		if (r.hit) begin
			if (m == MODE_NRU)
				nru_mark[s][w] = 1'b1;
			else if (m == MODE_LRU)
				touch_age(s, w);
		end else begin
			// Choose the way to allocate.
			if (m == MODE_RR) begin
				w = rr_next[s];
				rr_next[s] = rr_next[s] + 2'd1;
			end else begin
				found = 1'b0;
				for (int j = 0; j < NumWays; j++) begin
					if (!found && !line_valid[s][j]) begin
						found = 1'b1;
						w = j;
					end
				end
				if (!found && m == MODE_NRU) begin
					for (int j = 0; j < NumWays; j++) begin
						if (!nru_mark[s][j]) begin
							found = 1'b1;
							w = j;
						end
					end
					if (!found) begin
						for (int j = 0; j < NumWays; j++)
							nru_mark[s][j] = 1'b0;
						w = 0;
					end
				end else if (!found) begin
					w = 0;
					for (int j = 1; j < NumWays; j++)
						if (lru_age[s][j] > lru_age[s][w])
							w = j;
				end
			end
			if (line_valid[s][w]) begin
				r.evicted_valid = 1'b1;
				r.writeback_needed = line_dirty[s][w];
				r.victim_line = {tag_store[s][w], 6'(s)};
			end else begin
				r.filled_empty = 1'b1;
			end
			tag_store[s][w] = t;
			line_valid[s][w] = 1'b1;
			line_dirty[s][w] = 1'b0;
			nru_mark[s][w] = (m == MODE_NRU);
			if (m == MODE_LRU)
				touch_age(s, w);
		end
		if (is_write)
			line_dirty[s][w] = 1'b1;
		r.way = 2'(w);
		return r;
	endfunction

	// Offer one request, wait for its transaction and record the expectation.
	task automatic send_request(bit is_write, logic [25:0] addr, bit typed, lookup_t known);
		int gap;
		lookup_t predicted;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, addr, is_write};
		do @(posedge clk); while (!s_axis_tready);
		predicted = lookup_line(is_write, addr);
		pending_lookups.push_back(typed ? known : predicted);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_mode(mode_t m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		repl_mode = m;
	endtask

	// Mostly a few tags over a few sets so that hits and evictions are common.
	function automatic logic [25:0] pick_address();
		logic [19:0] tag_pool [8] = '{20'h0, 20'h1, 20'h2, 20'h3, 20'h5,
			20'hFFFFF, 20'h80000, 20'h55555};
		logic [5:0] set_pool [4] = '{6'd0, 6'd1, 6'd62, 6'd63};
		logic [5:0] s;
		if ($urandom_range(0, 9) < 2)
			return 26'($urandom);
		s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : set_pool[$urandom_range(0, 3)];
		return {tag_pool[$urandom_range(0, 7)], s};
	endfunction

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		got = m_axis_tdata;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fail_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (got.hit !== want.hit || got.way !== want.way
						|| got.filled_empty !== want.filled_empty
						|| got.evicted_valid !== want.evicted_valid
						|| got.writeback_needed !== want.writeback_needed
						|| got.victim_line !== want.victim_line) begin
					$display("%0t: mismatch expected hit=%b way=%0d fe=%b ev=%b wb=%b vl=%h",
						$time, want.hit, want.way, want.filled_empty, want.evicted_valid,
						want.writeback_needed, want.victim_line);
					$display("%0t:          actual   hit=%b way=%0d fe=%b ev=%b wb=%b vl=%h",
						$time, got.hit, got.way, got.filled_empty, got.evicted_valid,
						got.writeback_needed, got.victim_line);
					fail_count++;
				end
			end
		end
		// Receiver stalls: random bursts, plus one long hold-off on request.
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			stall_left = 300;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 18);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#3ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		req_row_t rows[$];
		mode_t phase_modes [6] = '{MODE_RR, MODE_NRU, MODE_ALT, MODE_LRU, MODE_RR, MODE_NRU};
		lookup_t k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		fail_count = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		stall_left = 0;
		repl_mode = MODE_LRU;
		for (int s = 0; s < NumSets; s++) begin
			rr_next[s] = '0;
			for (int j = 0; j < NumWays; j++) begin
				tag_store[s][j] = '0;
				line_valid[s][j] = 1'b0;
				line_dirty[s][j] = 1'b0;
				nru_mark[s][j] = 1'b0;
				lru_age[s][j] = '0;
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset mode, age-counter LRU.
		k = '0; k.filled_empty = 1'b1;
		rows.push_back('{0, 26'h0, 1, k});
		k = '0; k.hit = 1'b1;
		rows.push_back('{1, 26'h0, 1, k});
		k = '0; k.filled_empty = 1'b1;
		rows.push_back('{1, 26'h3FFFFFF, 1, k});
		rows.push_back('{0, 26'h40, 0, '0});
		rows.push_back('{0, 26'h80, 0, '0});
		rows.push_back('{0, 26'hC0, 0, '0});
		// Full set: the oldest way is the dirty line 0, which goes back to memory.
		k = '0; k.evicted_valid = 1'b1; k.writeback_needed = 1'b1;
		rows.push_back('{0, 26'h100, 1, k});
		rows.push_back('{1, 26'h3FFFFFF, 0, '0});
		rows.push_back('{0, 26'h3FFFFBF, 0, '0});
		rows.push_back('{0, 26'h3FFFF7F, 0, '0});
		rows.push_back('{1, 26'h3FFFF3F, 0, '0});
		rows.push_back('{0, 26'h2AAAAAA, 0, '0});
		rows.push_back('{1, 26'h1555555, 0, '0});
		rows.push_back('{0, 26'h3FFFEFF, 0, '0});
		rows.push_back('{0, 26'h40, 0, '0});
		rows.push_back('{0, 26'h140, 0, '0});
		foreach (rows[i])
			send_request(rows[i].is_write, rows[i].line_address, rows[i].typed, rows[i].known);
		drain();

		// Random phases, one replacement mode each.
		foreach (phase_modes[p]) begin
			write_mode(phase_modes[p]);
			if (p == 1)
				hold_req = 1'b1;
			if (p == 5)
				quiet = 1'b1;
			repeat (100)
				send_request($urandom_range(0, 1), pick_address(), 1'b0, '0);
			drain();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
